@@ rtl/core/stuffed_frame_transmitter_macros.svh @@
// ----------------------------------------------------------------------------
// Stuffed frame transmitter assertion macros
// Shared concurrent assertion forms for the transmitter modules.
// ----------------------------------------------------------------------------
`ifndef STUFFED_FRAME_TRANSMITTER_MACROS_SVH
`define STUFFED_FRAME_TRANSMITTER_MACROS_SVH

// Checked on every edge outside reset.
`define SFT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SFT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/sft_pkg.sv @@
// ----------------------------------------------------------------------------
// Stuffed frame transmitter package
// Line codes, register reset values, queue entry and sequencer types.
// ----------------------------------------------------------------------------
package sft_pkg;

  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ADDR_RESET = 8'hFF;
  localparam logic [7:0] CTRL_RESET = 8'h03;
  localparam logic [7:0] PROT_RESET = 8'h00;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STATION_ADDRESS = 2'd0,
    CFG_CONTROL_BYTE    = 2'd1,
    CFG_PROTOCOL_BYTE   = 2'd2
  } cfg_reg_t;

  // One classified payload item on its way to the sequencer.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hdr;
    logic       esc;
  } sft_entry_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_PROT,
    PH_ESC,
    PH_DATA,
    PH_CS_LO,
    PH_CS_HI,
    PH_END
  } phase_t;

endpackage

@@ rtl/core/stuffed_frame_transmitter.sv @@
// ----------------------------------------------------------------------------
// Stuffed frame transmitter
// Byte-stuffing framer with header, additive checksum and closing flag.
// ----------------------------------------------------------------------------
// Payload items enter on the in channel and come out as line bytes, one byte
// per clock at most. The first item of a frame is preceded by flag 0x7E and
// the address, control and protocol bytes; a payload 0x7E or 0x7D is preceded
// by escape 0x7D (the byte itself goes out unchanged). The item marked last
// is followed by the 16-bit sum of all header and stuffed bytes, low byte
// first, and the closing flag with frame_end set; run_last marks the final
// byte each item causes. An item therefore costs one line byte, two when it is
// escaped, plus four for a header and three for a trailer; the sequencer's
// single output register emits one line byte per cycle unless out_stall
// holds it. Items pass through a queue of QUEUE_DEPTH entries, so input is
// taken while a finished byte waits on a stalled output; a taken item enters
// the queue before its first byte is registered. Write registers only while idle.
// ----------------------------------------------------------------------------
module stuffed_frame_transmitter import sft_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             payload_byte,
  input  logic                   payload_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             line_byte,
  output logic                   run_last,
  output logic                   frame_end
);

  logic [7:0] station_address;
  logic [7:0] control_byte;
  logic [7:0] protocol_byte;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_head_valid;
  sft_entry_t q_entry;
  sft_entry_t q_head;

  // Header registers; drop writes to unused indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= ADDR_RESET;
      control_byte    <= CTRL_RESET;
      protocol_byte   <= PROT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STATION_ADDRESS: station_address <= cfg_data;
        CFG_CONTROL_BYTE:    control_byte    <= cfg_data;
        CFG_PROTOCOL_BYTE:   protocol_byte   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify: header needed, escape needed, frame close.
  sft_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .payload_byte (payload_byte),
    .payload_last (payload_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  // Hold classified items so each side stalls on its own.
  sft_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Advance through header, escape, data and trailer bytes.
  sft_back u_back (
    .clk             (clk),
    .rst             (rst),
    .station_address (station_address),
    .control_byte    (control_byte),
    .protocol_byte   (protocol_byte),
    .head_valid      (q_head_valid),
    .head            (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .line_byte       (line_byte),
    .run_last        (run_last),
    .frame_end       (frame_end)
  );

endmodule

@@ rtl/core/sft_front.sv @@
// ----------------------------------------------------------------------------
// Stuffed frame transmitter front end
// Accepts payload items, tracks frame opening and marks escapes.
// ----------------------------------------------------------------------------
module sft_front import sft_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] payload_byte,
  input  logic       payload_last,
  input  logic       q_full,
  output logic       q_push,
  output sft_entry_t q_entry
);

  logic in_frame;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.data = payload_byte;
    q_entry.last = payload_last;
    q_entry.hdr  = !in_frame;
    q_entry.esc  = (payload_byte == FLAG_BYTE) || (payload_byte == ESC_BYTE);
  end

  // Open on the first item, close on the one marked last.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
    end else if (q_push) begin
      in_frame <= !payload_last;
    end
  end

endmodule

@@ rtl/core/sft_queue.sv @@
// ----------------------------------------------------------------------------
// Stuffed frame transmitter item queue
// Short first-in first-out buffer between front end and sequencer.
// ----------------------------------------------------------------------------
module sft_queue import sft_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  sft_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output sft_entry_t head
);

  `include "stuffed_frame_transmitter_macros.svh"

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sft_entry_t         mem [DEPTH];
  logic [IDX_W-1:0]   wr_ptr;
  logic [IDX_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SFT_ASSERT(a_q_no_overflow, push |-> !full, "queue written while full")
  `SFT_ASSERT(a_q_no_underflow, pop |-> head_valid, "queue read while empty")
  `SFT_ASSERT(a_q_count_up, push && !pop |=> count == $past(count) + 1'b1,
              "queue count lost a write")

endmodule

@@ rtl/core/sft_back.sv @@
// ----------------------------------------------------------------------------
// Stuffed frame transmitter sequencer
// Expands each queued item into line bytes and keeps the running checksum.
// ----------------------------------------------------------------------------
module sft_back import sft_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] station_address,
  input  logic [7:0] control_byte,
  input  logic [7:0] protocol_byte,
  input  logic       head_valid,
  input  sft_entry_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] line_byte,
  output logic       run_last,
  output logic       frame_end
);

  `include "stuffed_frame_transmitter_macros.svh"

  phase_t      phase;
  phase_t      phase_next;
  phase_t      eff;
  logic        load;
  logic        done;
  logic [7:0]  byte_sel;
  logic [15:0] running_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    eff = phase;
    if (phase == PH_START) begin
      eff = head.hdr ? PH_FLAG : (head.esc ? PH_ESC : PH_DATA);
    end
    load     = head_valid && (!out_valid || !out_stall);
    done     = 1'b0;
    byte_sel = head.data;
    phase_next = phase;
    case (eff)
      PH_FLAG:  begin byte_sel = FLAG_BYTE;           phase_next = PH_ADDR; end
      PH_ADDR:  begin byte_sel = station_address;     phase_next = PH_CTRL; end
      PH_CTRL:  begin byte_sel = control_byte;        phase_next = PH_PROT; end
      PH_PROT:  begin
        byte_sel   = protocol_byte;
        phase_next = head.esc ? PH_ESC : PH_DATA;
      end
      PH_ESC:   begin byte_sel = ESC_BYTE;            phase_next = PH_DATA; end
      PH_DATA:  begin
        byte_sel   = head.data;
        phase_next = head.last ? PH_CS_LO : PH_START;
        done       = !head.last;
      end
      PH_CS_LO: begin byte_sel = running_sum[7:0];    phase_next = PH_CS_HI; end
      PH_CS_HI: begin byte_sel = running_sum[15:8];   phase_next = PH_END; end
      PH_END:   begin
        byte_sel   = FLAG_BYTE;
        phase_next = PH_START;
        done       = 1'b1;
      end
      default:  begin byte_sel = head.data;           phase_next = PH_START; end
    endcase
    if (!load) begin
      phase_next = phase;
      done       = 1'b0;
    end
    pop = done;
  end

  // Restart the sum on the opening flag; leave it alone over the trailer.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (load) begin
      if (eff == PH_FLAG) begin
        running_sum <= {8'h00, FLAG_BYTE};
      end else if (eff != PH_CS_LO && eff != PH_CS_HI && eff != PH_END) begin
        running_sum <= running_sum + {8'h00, byte_sel};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      line_byte <= byte_sel;
      run_last  <= done;
      frame_end <= (eff == PH_END);
    end
  end

  `SFT_ASSERT(a_end_closes_run, out_valid && frame_end |-> run_last,
              "closing flag not marked as last of its item")
  `SFT_ASSERT(a_flag_restarts_sum, load && eff == PH_FLAG |=> running_sum == 16'h007E,
              "checksum not restarted by opening flag")
  `SFT_ASSERT(a_pop_on_load, pop |-> load && (eff == PH_DATA || eff == PH_END),
              "item released without its final byte")
  `SFT_ASSERT_ALWAYS(a_idle_after_reset, $past(rst) |-> phase == PH_START,
              "sequencer not idle after reset")

endmodule
